>>> src/clas_pkg.sv
package clas_pkg;

	// Parser phases
	localparam logic [2:0] PH_START        = 3'd0;
	localparam logic [2:0] PH_FIRST_QUOTED = 3'd1;
	localparam logic [2:0] PH_FIRST_PLAIN  = 3'd2;
	localparam logic [2:0] PH_GAP          = 3'd3;
	localparam logic [2:0] PH_ARG          = 3'd4;
	localparam logic [2:0] PH_DROP         = 3'd5;

	// Result kinds
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	// Limits
	localparam logic [4:0] MAX_BACKSLASHES = 5'd31;
	localparam logic [8:0] MAX_ARGS        = 9'd256;

	// Characters
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;

	localparam logic [1:0] QUOTE_RUN_LIT = 2'd3;

	typedef struct packed {
		logic [2:0] phase;
		logic [1:0] quote_count;
		logic [4:0] pend_bs;
		logic       in_quote_run;
		logic [7:0] cur_arg;
		logic       ovf;
	} clas_state_t;

	localparam clas_state_t STATE_RESET = '{
		phase:        PH_START,
		quote_count:  2'd0,
		pend_bs:      5'd0,
		in_quote_run: 1'b0,
		cur_arg:      8'd0,
		ovf:          1'b0
	};

	// Results still owed for one item, in emission order:
	// held backslashes, one byte, argument end, line done
	typedef struct packed {
		logic [4:0] bs_cnt;
		logic       has_byte;
		logic [7:0] byte_val;
		logic       has_end;
		logic       has_done;
		logic [7:0] arg_idx;
		logic       ovf;
	} clas_plan_t;

endpackage

>>> src/clas_parse.sv
module clas_parse
	import clas_pkg::*;
(
	input  clas_state_t st,
	input  logic [7:0]  ch,
	input  logic        eol,
	output clas_state_t nxt,
	output clas_plan_t  plan
);

	logic blank;
	logic drop;

	assign blank = (ch == CH_SPACE) || (ch == CH_TAB);

	// Decode one item against the current state
	always_comb begin
		nxt = st;
		plan = '0;
		drop = 1'b0;
		unique case (st.phase)
			PH_FIRST_QUOTED: begin
				if (eol) begin
					plan.has_end = 1'b1;
					plan.has_done = 1'b1;
				end else if (ch == CH_QUOTE) begin
					plan.has_end = 1'b1;
					nxt.phase = PH_GAP;
				end else begin
					plan.has_byte = 1'b1;
					plan.byte_val = ch;
				end
			end
			PH_FIRST_PLAIN: begin
				if (eol) begin
					plan.has_end = 1'b1;
					plan.has_done = 1'b1;
				end else if (blank) begin
					plan.has_end = 1'b1;
					nxt.phase = PH_GAP;
				end else begin
					plan.has_byte = 1'b1;
					plan.byte_val = ch;
				end
			end
			PH_GAP, PH_ARG, PH_DROP: begin
				if (eol) begin
					if (st.phase != PH_GAP) begin
						plan.bs_cnt = st.pend_bs;
						plan.has_end = 1'b1;
					end
					plan.has_done = 1'b1;
				end else if (!(st.phase == PH_GAP && blank)) begin
					// open a new argument out of the gap
					if (st.phase == PH_GAP) begin
						if (({1'b0, st.cur_arg} + 9'd1) < MAX_ARGS) begin
							nxt.cur_arg = st.cur_arg + 8'd1;
							nxt.phase = PH_ARG;
						end else begin
							nxt.phase = PH_DROP;
						end
						nxt.quote_count = 2'd0;
						nxt.pend_bs = 5'd0;
						nxt.in_quote_run = 1'b0;
					end
					// argument byte
					if (nxt.in_quote_run && ch == CH_QUOTE) begin
						if (nxt.quote_count + 2'd1 == QUOTE_RUN_LIT) begin
							plan.has_byte = 1'b1;
							plan.byte_val = CH_QUOTE;
							nxt.quote_count = 2'd0;
						end else begin
							nxt.quote_count = nxt.quote_count + 2'd1;
						end
					end else begin
						if (nxt.in_quote_run) begin
							nxt.in_quote_run = 1'b0;
							if (nxt.quote_count == 2'd2)
								nxt.quote_count = 2'd0;
						end
						if (blank && nxt.quote_count == 2'd0) begin
							plan.bs_cnt = nxt.pend_bs;
							plan.has_end = 1'b1;
							nxt.pend_bs = 5'd0;
							nxt.phase = PH_GAP;
						end else if (ch == CH_BACKSLASH) begin
							if (nxt.pend_bs < MAX_BACKSLASHES)
								nxt.pend_bs = nxt.pend_bs + 5'd1;
							else
								nxt.ovf = 1'b1;
						end else if (ch == CH_QUOTE) begin
							plan.bs_cnt = {1'b0, nxt.pend_bs[4:1]};
							if (nxt.pend_bs[0]) begin
								plan.has_byte = 1'b1;
								plan.byte_val = CH_QUOTE;
							end else begin
								nxt.quote_count = nxt.quote_count + 2'd1;
							end
							nxt.pend_bs = 5'd0;
							nxt.in_quote_run = 1'b1;
						end else begin
							plan.bs_cnt = nxt.pend_bs;
							plan.has_byte = 1'b1;
							plan.byte_val = ch;
							nxt.pend_bs = 5'd0;
						end
					end
				end
				// arguments past the limit are parsed but give no bytes or ends
				drop = (st.phase == PH_DROP) ||
					(st.phase == PH_GAP && nxt.phase == PH_DROP);
			end
			default: begin
				if (eol) begin
					plan.has_end = 1'b1;
					plan.has_done = 1'b1;
				end else if (ch == CH_QUOTE) begin
					nxt.phase = PH_FIRST_QUOTED;
				end else if (blank) begin
					plan.has_end = 1'b1;
					nxt.phase = PH_GAP;
				end else begin
					plan.has_byte = 1'b1;
					plan.byte_val = ch;
					nxt.phase = PH_FIRST_PLAIN;
				end
			end
		endcase

		// drop argument output beyond the limit
		if (drop) begin
			plan.bs_cnt = 5'd0;
			plan.has_byte = 1'b0;
			plan.has_end = 1'b0;
		end

		plan.arg_idx = nxt.cur_arg;
		plan.ovf = nxt.ovf;

		// line done returns all state to reset
		if (plan.has_done)
			nxt = STATE_RESET;
	end

endmodule

>>> src/command_line_argument_splitter.sv
// Splits a command line, fed as one byte per item with a final end-of-line item
// (s_tuser high), into arguments by the usual command-line-to-argv rules. Each
// item yields zero or more results: argument bytes, argument ends, and at end of
// line a done result carrying the argument count; m_tlast marks the last result
// of an item. Items that yield one result stream at one per cycle while m_tready
// is high. An item that yields several results holds the input until its last
// result is sent, because a single output port drains the held backslash run
// (up to 31 bytes) plus byte, end and done results one per cycle while m_tready
// is high; held backslashes and blanks between arguments produce nothing.
module command_line_argument_splitter
	import clas_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        s_tuser,   // [0] end_of_line
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] out_byte, [15:8] arg_index,
	                               // [24:16] arg_count, [25] overflow, rest zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast    // last_of_run
);

	clas_state_t state_q;
	clas_state_t state_nxt;
	clas_plan_t  new_plan;
	clas_plan_t  plan_s1;
	clas_plan_t  plan_rest;
	logic        plan_vld_s1;
	logic        new_has;
	logic        pop;
	logic        pop_last;
	logic        accept;

	logic [1:0]  head_kind;
	logic [7:0]  head_byte;
	logic [7:0]  head_idx;
	logic [8:0]  head_cnt;

	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic [1:0]  m_tuser_q;
	logic        m_tlast_q;

	clas_parse u_parse (
		.st   (state_q),
		.ch   (s_tdata),
		.eol  (s_tuser),
		.nxt  (state_nxt),
		.plan (new_plan)
	);

	assign new_has = (new_plan.bs_cnt != 5'd0) || new_plan.has_byte ||
		new_plan.has_end || new_plan.has_done;

	// Pick the next result of the held plan
	always_comb begin
		plan_rest = plan_s1;
		head_byte = 8'd0;
		head_idx  = plan_s1.arg_idx;
		head_cnt  = 9'd0;
		priority if (plan_s1.bs_cnt != 5'd0) begin
			head_kind = KIND_BYTE;
			head_byte = CH_BACKSLASH;
			plan_rest.bs_cnt = plan_s1.bs_cnt - 5'd1;
		end else if (plan_s1.has_byte) begin
			head_kind = KIND_BYTE;
			head_byte = plan_s1.byte_val;
			plan_rest.has_byte = 1'b0;
		end else if (plan_s1.has_end) begin
			head_kind = KIND_END;
			plan_rest.has_end = 1'b0;
		end else begin
			head_kind = KIND_DONE;
			head_idx  = 8'd0;
			head_cnt  = {1'b0, plan_s1.arg_idx} + 9'd1;
			plan_rest.has_done = 1'b0;
		end
	end

	assign pop_last = (plan_rest.bs_cnt == 5'd0) && !plan_rest.has_byte &&
		!plan_rest.has_end && !plan_rest.has_done;
	assign pop      = plan_vld_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !plan_vld_s1 || (pop && pop_last);
	assign accept   = s_tvalid && s_tready;

	// Advance parser state on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// Hold the plan valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plan_vld_s1 <= 1'b0;
		end else if (accept && new_has) begin
			plan_vld_s1 <= 1'b1;
		end else if (pop && pop_last) begin
			plan_vld_s1 <= 1'b0;
		end
	end

	// Load a new plan or consume one result of it
	always_ff @(posedge clk) begin
		if (accept && new_has) begin
			plan_s1 <= new_plan;
		end else if (pop) begin
			plan_s1 <= plan_rest;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (pop) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			m_tuser_q <= head_kind;
			m_tlast_q <= pop_last;
			m_tdata_q <= {6'd0, plan_s1.ovf, head_cnt, head_idx, head_byte};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule
